[src/ssp_pkg.sv]
package ssp_pkg;

	localparam int FIELD_BUFFER = 32;
	localparam int LEN_W = $clog2(FIELD_BUFFER);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FIELD_BUFFER - 1);

	localparam logic [2:0] KIND_HRM   = 3'd0;
	localparam logic [2:0] KIND_CAD   = 3'd1;
	localparam logic [2:0] KIND_ANCS  = 3'd2;
	localparam logic [2:0] KIND_DWN   = 3'd3;
	localparam logic [2:0] KIND_DBG   = 3'd4;
	localparam logic [2:0] KIND_OTHER = 3'd5;
	localparam int NUM_KW = 5;

	localparam logic [3:0] FIELD_0   = 4'd0;
	localparam logic [3:0] FIELD_1   = 4'd1;
	localparam logic [3:0] FIELD_2   = 4'd2;
	localparam logic [3:0] FIELD_3   = 4'd3;
	localparam logic [3:0] FIELD_4   = 4'd4;
	localparam logic [3:0] FIELD_MAX = 4'd15;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;

	localparam logic [7:0] KW_TEXT [NUM_KW][4] = '{
		'{8'h48, 8'h52, 8'h4D, 8'h00},
		'{8'h43, 8'h41, 8'h44, 8'h00},
		'{8'h41, 8'h4E, 8'h43, 8'h53},
		'{8'h44, 8'h57, 8'h4E, 8'h00},
		'{8'h44, 8'h42, 8'h47, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd3, 3'd4, 3'd3, 3'd3};

	typedef enum logic [2:0] {
		PH_START,
		PH_INT,
		PH_POINT,
		PH_FRAC,
		PH_DONE
	} dec_phase_t;

	typedef struct packed {
		logic               done;
		logic [2:0]         kind;
		logic [31:0]        first_value;
		logic [31:0]        second_value;
		logic [31:0]        third_value;
		logic signed [31:0] speed_hundredths;
	} ssp_result_t;

	function automatic logic [31:0] acc_digit(input logic [31:0] acc, input logic [3:0] d);
		logic [35:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, d};
		acc_digit = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

[src/ssp_parser.sv]
module ssp_parser
	import ssp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [7:0]  ch,
	output ssp_result_t res
);

	logic              in_sentence_q, in_sentence_n;
	logic [3:0]        field_index_q, field_index_n;
	logic [LEN_W-1:0]  field_length_q, field_length_n;
	logic              field_truncated_q, field_truncated_n;
	logic              field_has_text_q, field_has_text_n;
	logic [NUM_KW-1:0] keyword_match_q, keyword_match_n;
	logic [2:0]        sentence_kind_q, sentence_kind_n;
	logic [31:0]       number_acc_q, number_acc_n;
	logic              digits_running_q, digits_running_n;
	dec_phase_t        decimal_phase_q, decimal_phase_n;
	logic              decimal_negative_q, decimal_negative_n;
	logic [6:0]        fraction_acc_q, fraction_acc_n;
	logic [31:0]       stored_q [9];
	logic [31:0]       stored_n [9];

	logic        is_digit;
	logic [3:0]  digit;
	logic [31:0] acc_next;
	logic [38:0] speed_mag;
	logic [31:0] speed_sat;
	logic [31:0] speed_val;
	logic        done;
	logic [2:0]  done_kind;
	logic [2:0]  kw_kind;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
	assign acc_next = acc_digit(number_acc_q, digit);

	// magnitude of the speed field, saturated to the positive signed range
	assign speed_mag = {7'd0, number_acc_q} * 39'd100 + {32'd0, fraction_acc_q};
	assign speed_sat = (speed_mag > {7'd0, SPEED_MAX}) ? SPEED_MAX : speed_mag[31:0];
	assign speed_val = decimal_negative_q ? (32'd0 - speed_sat) : speed_sat;

	always_comb begin
		kw_kind = KIND_OTHER;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (keyword_match_q[k]) begin
				kw_kind = 3'(k);
			end
		end
	end

	always_comb begin
		in_sentence_n      = in_sentence_q;
		field_index_n      = field_index_q;
		field_length_n     = field_length_q;
		field_truncated_n  = field_truncated_q;
		field_has_text_n   = field_has_text_q;
		keyword_match_n    = keyword_match_q;
		sentence_kind_n    = sentence_kind_q;
		number_acc_n       = number_acc_q;
		digits_running_n   = digits_running_q;
		decimal_phase_n    = decimal_phase_q;
		decimal_negative_n = decimal_negative_q;
		fraction_acc_n     = fraction_acc_q;
		for (int i = 0; i < 9; i++) begin
			stored_n[i] = stored_q[i];
		end
		done      = 1'b0;
		done_kind = KIND_HRM;

		if (ch == CH_DOLLAR || ch == CH_COMMA || ch == CH_CR || ch == CH_LF) begin
			if (ch == CH_DOLLAR) begin
				in_sentence_n   = 1'b1;
				field_index_n   = FIELD_0;
				sentence_kind_n = KIND_OTHER;
			end else if (in_sentence_q) begin
				if (field_length_q < LEN_LIMIT) begin
					if (field_index_q == FIELD_0) begin
						sentence_kind_n = kw_kind;
					end else if (sentence_kind_q != KIND_OTHER && field_has_text_q) begin
						case (sentence_kind_q)
							KIND_HRM: begin
								if (field_index_q == FIELD_1) begin
									stored_n[0] = number_acc_q;
								end else if (field_index_q == FIELD_2) begin
									stored_n[1] = number_acc_q;
									done = 1'b1;
								end
							end
							KIND_CAD: begin
								if (field_index_q == FIELD_1) begin
									stored_n[2] = number_acc_q;
								end else if (field_index_q == FIELD_2) begin
									stored_n[3] = speed_val;
									done = 1'b1;
								end
							end
							KIND_ANCS: begin
								if (field_index_q == FIELD_1) begin
									stored_n[4] = number_acc_q;
								end else if (field_index_q == FIELD_2) begin
									done = (stored_q[4] == 32'd0);
								end else if (field_index_q == FIELD_3) begin
									done = 1'b1;
								end
							end
							KIND_DWN: begin
								if (field_index_q == FIELD_1) begin
									stored_n[5] = number_acc_q;
									done = 1'b1;
								end
							end
							KIND_DBG: begin
								if (field_index_q == FIELD_1) begin
									stored_n[6] = number_acc_q;
								end else if (field_index_q == FIELD_2) begin
									stored_n[7] = number_acc_q;
								end else if (field_index_q == FIELD_3) begin
									stored_n[8] = number_acc_q;
									done = (stored_q[6] == 32'd0);
								end else if (field_index_q == FIELD_4) begin
									done = (stored_q[6] == 32'd1);
								end
							end
							default: begin
								done = 1'b0;
							end
						endcase
						done_kind = sentence_kind_q;
					end
				end
				if (field_index_q < FIELD_MAX) begin
					field_index_n = field_index_q + 4'd1;
				end
				if (done) begin
					in_sentence_n = 1'b0;
				end
			end
			// new field
			field_length_n     = '0;
			field_truncated_n  = 1'b0;
			field_has_text_n   = 1'b0;
			keyword_match_n    = '1;
			number_acc_n       = 32'd0;
			digits_running_n   = 1'b1;
			decimal_phase_n    = PH_START;
			decimal_negative_n = 1'b0;
			fraction_acc_n     = 7'd0;
		end else if (in_sentence_q && field_length_q < LEN_LIMIT) begin
			field_length_n = field_length_q + LEN_W'(1);
			if (!field_truncated_q) begin
				if (ch == CH_NUL) begin
					field_truncated_n = 1'b1;
				end else begin
					field_has_text_n = 1'b1;
					for (int k = 0; k < NUM_KW; k++) begin
						if ({{(LEN_W > 3 ? LEN_W - 3 : 0){1'b0}}, KW_LEN[k]} <= field_length_q
								|| KW_TEXT[k][field_length_q[1:0]] != ch) begin
							keyword_match_n[k] = 1'b0;
						end
					end
					if (sentence_kind_q == KIND_CAD && field_index_q == FIELD_2) begin
						case (decimal_phase_q)
							PH_START, PH_INT: begin
								if (decimal_phase_q == PH_START && ch == CH_MINUS) begin
									decimal_negative_n = 1'b1;
									decimal_phase_n    = PH_INT;
								end else if (is_digit) begin
									number_acc_n    = acc_next;
									decimal_phase_n = PH_INT;
								end else if (ch == CH_POINT) begin
									decimal_phase_n = PH_POINT;
								end else begin
									decimal_phase_n = PH_DONE;
								end
							end
							PH_POINT: begin
								if (is_digit) begin
									fraction_acc_n  = {digit, 3'b000} + {2'b00, digit, 1'b0};
									decimal_phase_n = PH_FRAC;
								end else begin
									decimal_phase_n = PH_DONE;
								end
							end
							PH_FRAC: begin
								if (is_digit) begin
									fraction_acc_n = fraction_acc_q + {3'b000, digit};
								end
								decimal_phase_n = PH_DONE;
							end
							default: begin
								decimal_phase_n = decimal_phase_q;
							end
						endcase
					end else if (digits_running_q && is_digit) begin
						number_acc_n = acc_next;
					end else begin
						digits_running_n = 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		res.done             = done;
		res.kind             = done_kind;
		res.first_value      = 32'd0;
		res.second_value     = 32'd0;
		res.third_value      = 32'd0;
		res.speed_hundredths = 32'sd0;
		case (done_kind)
			KIND_HRM: begin
				res.first_value  = stored_n[0];
				res.second_value = stored_n[1];
			end
			KIND_CAD: begin
				res.first_value      = stored_n[2];
				res.speed_hundredths = signed'(stored_n[3]);
			end
			KIND_ANCS: begin
				res.first_value = stored_n[4];
			end
			KIND_DWN: begin
				res.first_value = stored_n[5];
			end
			default: begin
				res.first_value  = stored_n[6];
				res.second_value = stored_n[7];
				res.third_value  = stored_n[8];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q      <= 1'b0;
			field_index_q      <= FIELD_0;
			field_length_q     <= '0;
			field_truncated_q  <= 1'b0;
			field_has_text_q   <= 1'b0;
			keyword_match_q    <= '1;
			sentence_kind_q    <= KIND_OTHER;
			number_acc_q       <= 32'd0;
			digits_running_q   <= 1'b1;
			decimal_phase_q    <= PH_START;
			decimal_negative_q <= 1'b0;
			fraction_acc_q     <= 7'd0;
			for (int i = 0; i < 9; i++) begin
				stored_q[i] <= 32'd0;
			end
		end else if (adv) begin
			in_sentence_q      <= in_sentence_n;
			field_index_q      <= field_index_n;
			field_length_q     <= field_length_n;
			field_truncated_q  <= field_truncated_n;
			field_has_text_q   <= field_has_text_n;
			keyword_match_q    <= keyword_match_n;
			sentence_kind_q    <= sentence_kind_n;
			number_acc_q       <= number_acc_n;
			digits_running_q   <= digits_running_n;
			decimal_phase_q    <= decimal_phase_n;
			decimal_negative_q <= decimal_negative_n;
			fraction_acc_q     <= fraction_acc_n;
			for (int i = 0; i < 9; i++) begin
				stored_q[i] <= stored_n[i];
			end
		end
	end

endmodule

[src/sensor_sentence_parser_core.sv]
// channel  direction  handshake                 payload
// in       input      in_valid / in_stall       ch
// out      output     out_valid / out_stall     kind, first_value, second_value,
//                                               third_value, speed_hundredths
//
// one character per cycle while in_stall is low; once the closing delimiter is taken, the result
// is presented after the input register, then the result register
// arst_n resets the parser state and clears the nine stored values to zero
// a held result stalls the input only once the input register is also full

module sensor_sentence_parser_core
	import ssp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         ch,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [31:0]        first_value,
	output logic [31:0]        second_value,
	output logic [31:0]        third_value,
	output logic signed [31:0] speed_hundredths
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        adv;
	ssp_result_t res;
	logic        out_valid_q;
	ssp_result_t res_q;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	ssp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ch     (ch_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && res.done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
		end
		if (adv && res.done) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = res_q.kind;
	assign first_value      = res_q.first_value;
	assign second_value     = res_q.second_value;
	assign third_value      = res_q.third_value;
	assign speed_hundredths = res_q.speed_hundredths;

endmodule
